// ----- sv/pps_pkg.sv -----
// ----------------------------------------------------------------------------
// pps_pkg
// Shared widths, constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package pps_pkg;

   localparam int COORD_W          = 32;
   localparam int DIST_W           = 52;
   localparam int LEN_W            = DIST_W + 1;
   localparam int REM_W            = LEN_W + 1;
   localparam int FRAC_BITS        = 30;
   localparam int QUOT_W           = FRAC_BITS + 1;
   localparam int PROD_W           = 2 * COORD_W + 1;
   localparam int NUM_AXES         = 3;
   localparam int NUM_COMP         = 5;
   localparam int COMP_IDX_W       = 3;
   localparam int AXIS_W           = 2;
   localparam int CSR_IDX_W        = 3;
   localparam int VIDX_W           = 7;
   localparam int STEP_W           = 5;
   localparam int MAX_OUT_VERTICES_DEF = 64;

   localparam logic signed [DIST_W-1:0] ON_TOL  = DIST_W'(65);
   localparam logic signed [LEN_W-1:0]  LEN_TOL = LEN_W'(6);
   localparam logic [QUOT_W-1:0]        Q_ONE   = QUOT_W'(1) << FRAC_BITS;

   localparam logic signed [COORD_W-1:0] NORMAL_Z_RST = COORD_W'(65536);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NORMAL_X = 3'd0,
      CSR_NORMAL_Y = 3'd1,
      CSR_NORMAL_Z = 3'd2,
      CSR_ANCHOR_X = 3'd3,
      CSR_ANCHOR_Y = 3'd4,
      CSR_ANCHOR_Z = 3'd5
   } csr_idx_type;

   typedef enum logic [1:0] {
      CLS_FRONT = 2'd0,
      CLS_BACK  = 2'd1,
      CLS_ON    = 2'd2
   } cls_type;

   typedef enum logic [1:0] {
      DSEL_CUR   = 2'd0,
      DSEL_PREV  = 2'd1,
      DSEL_FIRST = 2'd2
   } dsel_type;

   typedef struct packed {
      logic                  load_item;
      logic                  dist_en;
      dsel_type              dist_sel;
      logic [AXIS_W-1:0]     axis;
      logic                  start_poly;
      logic                  cut_setup;
      logic                  cut_close;
      logic                  div_step;
      logic                  interp_en;
      logic [COMP_IDX_W-1:0] interp_k;
      logic                  emit;
      logic                  emit_side;
      logic                  emit_cut;
      logic                  flush;
      logic                  commit;
   } cmd_type;

   typedef struct packed {
      cls_type cls;
      cls_type first_class;
      logic    idx_zero;
      logic    last;
      logic    cut_ok;
      logic    emit_ok;
      logic    flush_ok;
   } status_type;

endpackage

// ----- sv/pps_datapath.sv -----
// ----------------------------------------------------------------------------
// pps_datapath
// Vertex storage, plane distance, crossing divider, interpolation and the
// pending/output result registers.
// ----------------------------------------------------------------------------
module pps_datapath
   import pps_pkg::*;
#(
   parameter int MAX_OUT_VERTICES = MAX_OUT_VERTICES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  cmd_type                   cmd,
   output status_type                status,
   input  logic signed [COORD_W-1:0] req_vertex_x,
   input  logic signed [COORD_W-1:0] req_vertex_y,
   input  logic signed [COORD_W-1:0] req_vertex_z,
   input  logic signed [COORD_W-1:0] req_vertex_u,
   input  logic signed [COORD_W-1:0] req_vertex_v,
   input  logic                      req_final_vertex,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_side,
   output logic signed [COORD_W-1:0] rsp_out_x,
   output logic signed [COORD_W-1:0] rsp_out_y,
   output logic signed [COORD_W-1:0] rsp_out_z,
   output logic signed [COORD_W-1:0] rsp_out_u,
   output logic signed [COORD_W-1:0] rsp_out_v,
   output logic                      rsp_is_cut_point,
   output logic                      rsp_overflow,
   output logic                      rsp_run_end,
   input  logic                      csr_wr_en,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [COORD_W-1:0]        csr_data
);

   localparam int CNT_W = $clog2(MAX_OUT_VERTICES + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_OUT_VERTICES);

   logic signed [COORD_W-1:0] normal_ff [NUM_AXES];
   logic signed [COORD_W-1:0] anchor_ff [NUM_AXES];
   logic signed [COORD_W-1:0] cur_ff    [NUM_COMP];
   logic signed [COORD_W-1:0] prev_ff   [NUM_COMP];
   logic signed [COORD_W-1:0] first_ff  [NUM_COMP];
   logic signed [COORD_W-1:0] cutv_ff   [NUM_COMP];
   logic                      last_ff;
   logic signed [DIST_W-1:0]  acc_ff, dcur_ff, dprev_ff, dfirst_ff;
   cls_type                   first_class_ff;
   logic [VIDX_W-1:0]         vidx_ff;
   logic [CNT_W-1:0]          front_cnt_ff, back_cnt_ff;
   logic                      close_ff, eq_ff;
   logic [REM_W-1:0]          rem_ff;
   logic [LEN_W-1:0]          ul_ff;
   logic [QUOT_W-1:0]         q_ff;

   logic                      pend_valid_ff, pend_side_ff, pend_cut_ff, pend_ovf_ff;
   logic signed [COORD_W-1:0] pend_vtx_ff [NUM_COMP];
   logic                      out_valid_ff, out_side_ff, out_cut_ff, out_ovf_ff, out_end_ff;
   logic signed [COORD_W-1:0] out_vtx_ff  [NUM_COMP];

   // distance / interpolation multiplier
   logic signed [COORD_W:0]   mul_a;
   logic signed [COORD_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  prod;
   logic signed [COORD_W-1:0] pt, ia, ib;
   logic signed [DIST_W-1:0]  term, dsum;
   logic [QUOT_W-1:0]         qv;

   always_comb begin
      unique case (cmd.dist_sel)
         DSEL_PREV:  pt = prev_ff[cmd.axis];
         DSEL_FIRST: pt = first_ff[cmd.axis];
         default:    pt = cur_ff[cmd.axis];
      endcase
      ia = close_ff ? cur_ff[cmd.interp_k]   : prev_ff[cmd.interp_k];
      ib = close_ff ? first_ff[cmd.interp_k] : cur_ff[cmd.interp_k];
      qv = eq_ff ? Q_ONE : q_ff;
      if (cmd.interp_en) begin
         mul_a = (COORD_W+1)'(ib) - (COORD_W+1)'(ia);
         mul_b = COORD_W'({1'b0, qv});
      end else begin
         mul_a = (COORD_W+1)'(anchor_ff[cmd.axis]) - (COORD_W+1)'(pt);
         mul_b = normal_ff[cmd.axis];
      end
      prod = PROD_W'(mul_a) * PROD_W'(mul_b);
      term = DIST_W'(prod >>> 16);
      dsum = (cmd.axis == '0) ? term : acc_ff + term;
   end

   // crossing setup
   logic signed [DIST_W-1:0] da, db;
   logic signed [LEN_W-1:0]  len;
   logic [LEN_W-1:0]         ua, ul;
   logic                     cut_ok;

   always_comb begin
      da = cmd.cut_close ? dcur_ff   : dprev_ff;
      db = cmd.cut_close ? dfirst_ff : dcur_ff;
      len = LEN_W'(da) - LEN_W'(db);
      ua  = da[DIST_W-1] ? LEN_W'(-LEN_W'(da)) : LEN_W'(da);
      ul  = len[LEN_W-1] ? LEN_W'(-len) : LEN_W'(len);
      cut_ok = 1'b1;
      if (len <= LEN_TOL && len >= -LEN_TOL) cut_ok = 1'b0;
      if (da != '0 && (da[DIST_W-1] != len[LEN_W-1])) cut_ok = 1'b0;
      if (ua > ul) cut_ok = 1'b0;
   end

   logic [REM_W-1:0] rem_sh;
   always_comb rem_sh = rem_ff << 1;

   // classification of the current vertex
   cls_type cls;
   always_comb begin
      if (dcur_ff > ON_TOL) cls = CLS_BACK;
      else if (dcur_ff < -ON_TOL) cls = CLS_FRONT;
      else cls = CLS_ON;
   end

   logic out_free;
   always_comb begin
      out_free = !out_valid_ff || !rsp_stall;
      status.cls         = cls;
      status.first_class = first_class_ff;
      status.idx_zero    = (vidx_ff == '0);
      status.last        = last_ff;
      status.cut_ok      = cut_ok;
      status.emit_ok     = !pend_valid_ff || out_free;
      status.flush_ok    = out_free;
   end

   logic new_ovf;
   always_comb begin
      if (cmd.emit_side) new_ovf = (back_cnt_ff >= CNT_MAX);
      else new_ovf = (front_cnt_ff >= CNT_MAX);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         normal_ff[0]   <= '0;
         normal_ff[1]   <= '0;
         normal_ff[2]   <= NORMAL_Z_RST;
         anchor_ff[0]   <= '0;
         anchor_ff[1]   <= '0;
         anchor_ff[2]   <= '0;
         first_class_ff <= CLS_FRONT;
         vidx_ff        <= '0;
         front_cnt_ff   <= '0;
         back_cnt_ff    <= '0;
         pend_valid_ff  <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_NORMAL_X: normal_ff[0] <= csr_data;
               CSR_NORMAL_Y: normal_ff[1] <= csr_data;
               CSR_NORMAL_Z: normal_ff[2] <= csr_data;
               CSR_ANCHOR_X: anchor_ff[0] <= csr_data;
               CSR_ANCHOR_Y: anchor_ff[1] <= csr_data;
               CSR_ANCHOR_Z: anchor_ff[2] <= csr_data;
               default: ;
            endcase
         end
         if (cmd.start_poly) begin
            first_class_ff <= cls;
            front_cnt_ff   <= '0;
            back_cnt_ff    <= '0;
         end
         if (cmd.emit && !new_ovf) begin
            if (cmd.emit_side) back_cnt_ff <= back_cnt_ff + 1'b1;
            else front_cnt_ff <= front_cnt_ff + 1'b1;
         end
         if (cmd.commit) begin
            if (last_ff) vidx_ff <= '0;
            else if (vidx_ff != '1) vidx_ff <= vidx_ff + 1'b1;
         end
         if ((cmd.emit && pend_valid_ff) || cmd.flush) out_valid_ff <= 1'b1;
         else if (!rsp_stall) out_valid_ff <= 1'b0;
         if (cmd.emit) pend_valid_ff <= 1'b1;
         else if (cmd.flush) pend_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         cur_ff[0] <= req_vertex_x;
         cur_ff[1] <= req_vertex_y;
         cur_ff[2] <= req_vertex_z;
         cur_ff[3] <= req_vertex_u;
         cur_ff[4] <= req_vertex_v;
         last_ff   <= req_final_vertex;
      end
      if (cmd.dist_en) begin
         acc_ff <= dsum;
         if (cmd.axis == AXIS_W'(NUM_AXES - 1)) begin
            unique case (cmd.dist_sel)
               DSEL_PREV:  dprev_ff  <= dsum;
               DSEL_FIRST: dfirst_ff <= dsum;
               default:    dcur_ff   <= dsum;
            endcase
         end
      end
      if (cmd.start_poly) first_ff <= cur_ff;
      if (cmd.commit) prev_ff <= cur_ff;
      if (cmd.cut_setup) begin
         close_ff <= cmd.cut_close;
         eq_ff    <= (ua == ul);
         rem_ff   <= REM_W'(ua);
         ul_ff    <= ul;
         q_ff     <= '0;
      end
      if (cmd.div_step) begin
         if (rem_sh >= REM_W'(ul_ff)) begin
            rem_ff <= rem_sh - REM_W'(ul_ff);
            q_ff   <= {q_ff[QUOT_W-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            q_ff   <= {q_ff[QUOT_W-2:0], 1'b0};
         end
      end
      if (cmd.interp_en) cutv_ff[cmd.interp_k] <= ia + prod[FRAC_BITS +: COORD_W];
      if (cmd.emit) begin
         pend_side_ff <= cmd.emit_side;
         pend_cut_ff  <= cmd.emit_cut;
         pend_ovf_ff  <= new_ovf;
         if (cmd.emit_cut) pend_vtx_ff <= cutv_ff;
         else pend_vtx_ff <= cur_ff;
      end
      if ((cmd.emit && pend_valid_ff) || cmd.flush) begin
         out_side_ff <= pend_side_ff;
         out_cut_ff  <= pend_cut_ff;
         out_ovf_ff  <= pend_ovf_ff;
         out_vtx_ff  <= pend_vtx_ff;
         out_end_ff  <= cmd.flush;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_side         = out_side_ff;
   assign rsp_out_x        = out_vtx_ff[0];
   assign rsp_out_y        = out_vtx_ff[1];
   assign rsp_out_z        = out_vtx_ff[2];
   assign rsp_out_u        = out_vtx_ff[3];
   assign rsp_out_v        = out_vtx_ff[4];
   assign rsp_is_cut_point = out_cut_ff;
   assign rsp_overflow     = out_ovf_ff;
   assign rsp_run_end      = out_end_ff;

endmodule

// ----- sv/pps_ctrl.sv -----
// ----------------------------------------------------------------------------
// pps_ctrl
// Sequencer: distances, crossing division, interpolation and emit order.
// ----------------------------------------------------------------------------
module pps_ctrl
   import pps_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [17:0] {
      S_IDLE     = 18'h00001,
      S_DCUR     = 18'h00002,
      S_CLASS    = 18'h00004,
      S_FIRST_E1 = 18'h00008,
      S_FIRST_E2 = 18'h00010,
      S_DPREV    = 18'h00020,
      S_MAIN     = 18'h00040,
      S_ON_E1    = 18'h00080,
      S_ON_E2    = 18'h00100,
      S_DIV      = 18'h00200,
      S_INTERP   = 18'h00400,
      S_CUT_E1   = 18'h00800,
      S_CUT_E2   = 18'h01000,
      S_EMIT_CUR = 18'h02000,
      S_CLOSE    = 18'h04000,
      S_DFIRST   = 18'h08000,
      S_CSET     = 18'h10000,
      S_FLUSH    = 18'h20000
   } state_type;

   state_type          state_ff, state_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               close_ff, close_in;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      close_in = close_ff;
      cmd      = '0;
      cmd.axis     = step_ff[AXIS_W-1:0];
      cmd.interp_k = step_ff[COMP_IDX_W-1:0];
      cmd.cut_close = close_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               step_in  = '0;
               close_in = 1'b0;
               state_in = S_DCUR;
            end
         end
         S_DCUR, S_DPREV, S_DFIRST: begin
            cmd.dist_en  = 1'b1;
            cmd.dist_sel = (state_ff == S_DPREV)  ? DSEL_PREV :
                           (state_ff == S_DFIRST) ? DSEL_FIRST : DSEL_CUR;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(NUM_AXES - 1)) begin
               step_in  = '0;
               state_in = (state_ff == S_DPREV)  ? S_MAIN :
                          (state_ff == S_DFIRST) ? S_CSET : S_CLASS;
            end
         end
         S_CLASS: begin
            if (status.idx_zero) begin
               cmd.start_poly = 1'b1;
               state_in = S_FIRST_E1;
            end else begin
               state_in = S_DPREV;
            end
         end
         S_FIRST_E1: begin
            if (status.emit_ok) begin
               cmd.emit      = 1'b1;
               cmd.emit_side = (status.cls != CLS_FRONT);
               state_in = (status.cls == CLS_ON) ? S_FIRST_E2 : S_FLUSH;
            end
         end
         S_FIRST_E2, S_ON_E2: begin
            if (status.emit_ok) begin
               cmd.emit = 1'b1;
               state_in = (state_ff == S_ON_E2) ? S_CLOSE : S_FLUSH;
            end
         end
         S_MAIN: begin
            if (status.cls == CLS_ON) begin
               state_in = S_ON_E1;
            end else begin
               cmd.cut_setup = 1'b1;
               cmd.cut_close = 1'b0;
               state_in = status.cut_ok ? S_DIV : S_EMIT_CUR;
            end
         end
         S_ON_E1: begin
            if (status.emit_ok) begin
               cmd.emit      = 1'b1;
               cmd.emit_side = 1'b1;
               state_in = S_ON_E2;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(FRAC_BITS - 1)) begin
               step_in  = '0;
               state_in = S_INTERP;
            end
         end
         S_INTERP: begin
            cmd.interp_en = 1'b1;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(NUM_COMP - 1)) begin
               step_in  = '0;
               state_in = S_CUT_E1;
            end
         end
         S_CUT_E1: begin
            if (status.emit_ok) begin
               cmd.emit      = 1'b1;
               cmd.emit_cut  = 1'b1;
               cmd.emit_side = close_ff ? !status.first_class[0] : !status.cls[0];
               state_in = S_CUT_E2;
            end
         end
         S_CUT_E2: begin
            if (status.emit_ok) begin
               cmd.emit      = 1'b1;
               cmd.emit_cut  = 1'b1;
               cmd.emit_side = close_ff ? status.first_class[0] : status.cls[0];
               state_in = close_ff ? S_FLUSH : S_EMIT_CUR;
            end
         end
         S_EMIT_CUR: begin
            if (status.emit_ok) begin
               cmd.emit      = 1'b1;
               cmd.emit_side = status.cls[0];
               state_in = S_CLOSE;
            end
         end
         S_CLOSE: begin
            if (status.last && status.first_class != CLS_ON) begin
               step_in  = '0;
               close_in = 1'b1;
               state_in = S_DFIRST;
            end else begin
               state_in = S_FLUSH;
            end
         end
         S_CSET: begin
            cmd.cut_setup = 1'b1;
            cmd.cut_close = 1'b1;
            state_in = status.cut_ok ? S_DIV : S_FLUSH;
         end
         S_FLUSH: begin
            if (status.flush_ok) begin
               cmd.flush  = 1'b1;
               cmd.commit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
         close_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         close_ff <= close_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

// ----- sv/polygon_plane_split_core.sv -----
// ----------------------------------------------------------------------------
// polygon_plane_split_core
// Streams a convex polygon one vertex per item and splits it by a plane.
// ----------------------------------------------------------------------------
// Usage: send vertices on req_* (valid/stall), final_vertex on the last one.
// Each vertex item yields one to five result items on rsp_*, tagged front or
// back; run_end marks the last result of an item. The plane (normal and an
// anchor point, Q16.16) must be written by the user through csr_* only while
// the block is idle; the block itself does not enforce this. One item is
// worked at a time; a point's distance is summed one axis per cycle on one
// shared multiplier. A later vertex also needs the previous distance, and a
// crossing (restoring divider, interpolation, two cut emits) when its edge
// crosses the plane; the final vertex does the same for the closing edge.
// Results pass through a pending stage and an output register, so the
// next item is accepted while the last result still waits at rsp_*.
// A stalled receiver holds the output register; the sequencer waits at
// its emit steps until room frees up. Synchronous reset returns the plane
// to normal (0,0,1), anchor 0, and clears list counts and vertex index.
// ----------------------------------------------------------------------------
module polygon_plane_split_core
   import pps_pkg::*;
#(
   parameter int MAX_OUT_VERTICES = MAX_OUT_VERTICES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [COORD_W-1:0] req_vertex_x,
   input  logic signed [COORD_W-1:0] req_vertex_y,
   input  logic signed [COORD_W-1:0] req_vertex_z,
   input  logic signed [COORD_W-1:0] req_vertex_u,
   input  logic signed [COORD_W-1:0] req_vertex_v,
   input  logic                      req_final_vertex,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_side,
   output logic signed [COORD_W-1:0] rsp_out_x,
   output logic signed [COORD_W-1:0] rsp_out_y,
   output logic signed [COORD_W-1:0] rsp_out_z,
   output logic signed [COORD_W-1:0] rsp_out_u,
   output logic signed [COORD_W-1:0] rsp_out_v,
   output logic                      rsp_is_cut_point,
   output logic                      rsp_overflow,
   output logic                      rsp_run_end,
   input  logic                      csr_wr_en,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [COORD_W-1:0]        csr_data
);

   cmd_type    cmd;
   status_type status;

   pps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   pps_datapath #(
      .MAX_OUT_VERTICES (MAX_OUT_VERTICES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_vertex_x     (req_vertex_x),
      .req_vertex_y     (req_vertex_y),
      .req_vertex_z     (req_vertex_z),
      .req_vertex_u     (req_vertex_u),
      .req_vertex_v     (req_vertex_v),
      .req_final_vertex (req_final_vertex),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_side         (rsp_side),
      .rsp_out_x        (rsp_out_x),
      .rsp_out_y        (rsp_out_y),
      .rsp_out_z        (rsp_out_z),
      .rsp_out_u        (rsp_out_u),
      .rsp_out_v        (rsp_out_v),
      .rsp_is_cut_point (rsp_is_cut_point),
      .rsp_overflow     (rsp_overflow),
      .rsp_run_end      (rsp_run_end),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

endmodule
